// ===== rtl/dbwc_pkg.sv =====
package dbwc_pkg;

   localparam int RTT_W             = 24;
   localparam int WIN_W             = 16;
   localparam int HOLD_W            = 10;
   localparam int ACT_W             = 2;
   localparam int STREAK_W          = 32;
   localparam int CSR_IDX_W         = 2;
   localparam int CSR_DATA_W        = 24;
   localparam int PROD_W            = RTT_W + WIN_W;
   localparam int HISTORY_DEPTH_DEF = 10;

   localparam logic [RTT_W-1:0]    ALPHA_RST  = 24'd1000000;
   localparam logic [RTT_W-1:0]    BETA_RST   = 24'd3000000;
   localparam logic [HOLD_W-1:0]   HOLD_RST   = 10'd100;
   localparam logic [WIN_W-1:0]    WIN_RST    = 16'd10;
   localparam logic [WIN_W-1:0]    WIN_MAX    = {WIN_W{1'b1}};
   localparam logic [WIN_W-1:0]    WIN_MIN    = 16'd1;
   localparam logic [RTT_W-1:0]    MIN_RTT_RST = {RTT_W{1'b1}};
   localparam logic [STREAK_W-1:0] STREAK_MAX = {STREAK_W{1'b1}};

   typedef enum logic [ACT_W-1:0] {
      ACT_HOLD = 2'd0,
      ACT_INC  = 2'd1,
      ACT_DEC  = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA = 2'd0,
      CSR_BETA  = 2'd1,
      CSR_HOLD  = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SUM,
      ST_MUL_HOLD,
      ST_MUL_ALPHA,
      ST_MUL_BETA,
      ST_DECIDE,
      ST_OUT
   } state_type;

endpackage

// ===== rtl/delay_based_window_control_unit.sv =====
// a request passes through the update, a serial sum over the stored delays, the hold, alpha
//   and beta products, the decision and the output register; the sum takes longer as the history fills
// a new transaction is taken only once the last has reached the output register; req_ready is high only when idle
// one shared 24x16 multiplier forms window*hold_factor, alpha*count and beta*count in turn
// reset (synchronous, active high): window 10, streak 0, min rtt all ones, history empty,
//   registers alpha 1000000, beta 3000000, hold factor 100; no clearing pass
module delay_based_window_control_unit #(
   parameter int HISTORY_DEPTH = dbwc_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [dbwc_pkg::RTT_W-1:0]      req_rtt_us,
   input  logic [dbwc_pkg::WIN_W-1:0]      req_echoed_window,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [dbwc_pkg::WIN_W-1:0]      rsp_cwnd,
   output logic [dbwc_pkg::ACT_W-1:0]      rsp_action,
   input  logic                            csr_we,
   input  logic [dbwc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dbwc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dbwc_pkg::*;

   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = RTT_W + CNT_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(HISTORY_DEPTH - 1);

   state_type state_ff, state_in;

   logic [RTT_W-1:0]    alpha_ff, beta_ff;
   logic [HOLD_W-1:0]   hold_ff;

   logic [RTT_W-1:0]    rtt_ff, rtt_in;
   logic [WIN_W-1:0]    echoed_ff, echoed_in;
   logic [RTT_W-1:0]    min_rtt_ff, min_rtt_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic [RTT_W-1:0]    rd_data_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [STREAK_W-1:0] streak_ff, streak_in;
   logic [WIN_W-1:0]    window_ff, window_in;
   action_type          action_ff, action_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                hold_ok_ff, hold_ok_in;
   logic                lt_alpha_ff, lt_alpha_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WIN_W-1:0]    rsp_window_ff, rsp_window_in;
   action_type          rsp_action_ff, rsp_action_in;

   logic [RTT_W-1:0]    hist_mem_ff [HISTORY_DEPTH];
   logic                mem_we;
   logic [RTT_W-1:0]    delay;
   logic [PTR_W-1:0]    rd_addr;
   logic [RTT_W-1:0]    mul_a;
   logic [WIN_W-1:0]    mul_b;
   logic                gt_beta;
   logic                req_fire;
   logic                out_free;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cwnd   = rsp_window_ff;
   assign rsp_action = rsp_action_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_fire) state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_SUM;
         ST_SUM:       if (idx_ff == count_ff && rd_vld_ff) state_in = ST_MUL_HOLD;
         ST_MUL_HOLD:  state_in = ST_MUL_ALPHA;
         ST_MUL_ALPHA: state_in = ST_MUL_BETA;
         ST_MUL_BETA:  state_in = ST_DECIDE;
         ST_DECIDE:    state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      rtt_in        = rtt_ff;
      echoed_in     = echoed_ff;
      min_rtt_in    = min_rtt_ff;
      count_in      = count_ff;
      wr_ptr_in     = wr_ptr_ff;
      idx_in        = idx_ff;
      rd_vld_in     = 1'b0;
      sum_in        = sum_ff;
      streak_in     = streak_ff;
      window_in     = window_ff;
      action_in     = action_ff;
      hold_ok_in    = hold_ok_ff;
      lt_alpha_in   = lt_alpha_ff;
      rsp_window_in = rsp_window_ff;
      rsp_action_in = rsp_action_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_we        = 1'b0;
      rd_addr       = idx_ff[PTR_W-1:0];
      mul_a         = RTT_W'(hold_ff);
      mul_b         = window_ff;
      gt_beta       = PROD_W'(sum_ff) > prod_ff;
      delay         = rtt_ff - ((rtt_ff < min_rtt_ff) ? rtt_ff : min_rtt_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               rtt_in    = req_rtt_us;
               echoed_in = req_echoed_window;
            end
         end
         ST_UPDATE: begin
            if (rtt_ff < min_rtt_ff) min_rtt_in = rtt_ff;
            mem_we = 1'b1;
            if (count_ff != DEPTH_CNT) count_in = count_ff + 1'b1;
            wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
            if (echoed_ff == window_ff && streak_ff != STREAK_MAX)
               streak_in = streak_ff + 1'b1;
            idx_in = '0;
            sum_in = '0;
         end
         ST_SUM: begin
            // read data is registered and added in the cycle after the read is issued
            if (rd_vld_ff) sum_in = sum_ff + SUM_W'(rd_data_ff);
            if (idx_ff != count_ff) begin
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + 1'b1;
            end
         end
         ST_MUL_HOLD: begin
            mul_a = RTT_W'(hold_ff);
            mul_b = window_ff;
         end
         ST_MUL_ALPHA: begin
            hold_ok_in = PROD_W'(streak_ff) >= prod_ff;
            mul_a      = alpha_ff;
            mul_b      = WIN_W'(count_ff);
         end
         ST_MUL_BETA: begin
            lt_alpha_in = PROD_W'(sum_ff) < prod_ff;
            mul_a       = beta_ff;
            mul_b       = WIN_W'(count_ff);
         end
         ST_DECIDE: begin
            action_in = ACT_HOLD;
            if (hold_ok_ff) begin
               if (lt_alpha_ff) begin
                  if (window_ff != WIN_MAX) begin
                     window_in = window_ff + 1'b1;
                     action_in = ACT_INC;
                  end
                  streak_in = '0;
               end else if (gt_beta) begin
                  if (window_ff > WIN_MIN) begin
                     window_in = window_ff - 1'b1;
                     action_in = ACT_DEC;
                  end
                  streak_in = '0;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_window_in = window_ff;
               rsp_action_in = action_ff;
            end
         end
         default: ;
      endcase

      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_rtt_ff   <= MIN_RTT_RST;
         count_ff     <= '0;
         wr_ptr_ff    <= '0;
         streak_ff    <= '0;
         window_ff    <= WIN_RST;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_rtt_ff   <= min_rtt_in;
         count_ff     <= count_in;
         wr_ptr_ff    <= wr_ptr_in;
         streak_ff    <= streak_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RST;
         beta_ff  <= BETA_RST;
         hold_ff  <= HOLD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_wdata[RTT_W-1:0];
            CSR_BETA:  beta_ff  <= csr_wdata[RTT_W-1:0];
            CSR_HOLD:  hold_ff  <= csr_wdata[HOLD_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rtt_ff        <= rtt_in;
      echoed_ff     <= echoed_in;
      idx_ff        <= idx_in;
      sum_ff        <= sum_in;
      action_ff     <= action_in;
      prod_ff       <= prod_in;
      hold_ok_ff    <= hold_ok_in;
      lt_alpha_ff   <= lt_alpha_in;
      rsp_window_ff <= rsp_window_in;
      rsp_action_ff <= rsp_action_in;
   end

   // delay history, circular; the sum does not depend on order
   always_ff @(posedge clock) begin
      if (mem_we) hist_mem_ff[wr_ptr_ff] <= delay;
      rd_data_ff <= hist_mem_ff[rd_addr];
   end

endmodule

// ===== rtl/dbwc_checker.sv =====
module dbwc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [dbwc_pkg::WIN_W-1:0]      rsp_cwnd,
   input logic [dbwc_pkg::ACT_W-1:0]      rsp_action
);

   // window never drops to zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cwnd != '0)
      else $error("window reported as zero");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cwnd) && $stable(rsp_action))
      else $error("response changed while stalled");

   // one transaction at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a response does not rise straight after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 !$rose(rsp_valid))
      else $error("response appeared too early");

endmodule

bind delay_based_window_control_unit dbwc_checker u_dbwc_checker (.*);

// ===== tb/tb_delay_based_window_control_unit.sv =====
module tb_delay_based_window_control_unit;
   import dbwc_pkg::*;

   localparam int HIST        = HISTORY_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct {
      logic [RTT_W-1:0] rtt;
      logic [WIN_W-1:0] echoed;
      bit               track;   // echo the window the bench predicts at send time
   } ack_type;

   typedef struct {
      logic [WIN_W-1:0] window;
      action_type       act;
   } decision_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [RTT_W-1:0]      req_rtt_us = '0;
   logic [WIN_W-1:0]      req_echoed_window = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WIN_W-1:0]      rsp_cwnd;
   logic [ACT_W-1:0]      rsp_action;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predicted block state and register copies
   logic [RTT_W-1:0]    rtt_floor = MIN_RTT_RST;
   logic [RTT_W-1:0]    delay_hist [HIST];
   int                  delay_cnt = 0;
   logic [STREAK_W-1:0] streak_cnt = '0;
   logic [WIN_W-1:0]    cwnd = WIN_RST;
   logic [RTT_W-1:0]    alpha_cfg = ALPHA_RST;
   logic [RTT_W-1:0]    beta_cfg = BETA_RST;
   logic [HOLD_W-1:0]   hold_cfg = HOLD_RST;

   ack_type      ack_backlog [$];
   decision_type queued_decisions [$];
   ack_type      next_ack;
   decision_type seen;
   logic      req_taken = 1'b0;
   int        req_gap = 0;
   int        rsp_stall = 0;
   bit        calm = 1'b0;
   int        fail_count = 0;
   int        cycle_count = 0;

   delay_based_window_control_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rtt_us        (req_rtt_us),
      .req_echoed_window (req_echoed_window),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cwnd          (rsp_cwnd),
      .rsp_action        (rsp_action),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic decide_window(input logic [RTT_W-1:0] rtt, input logic [WIN_W-1:0] echoed);
      logic [63:0]  delay_sum;
      decision_type d;
      delay_sum = '0;
      d.act = ACT_HOLD;
      if (rtt < rtt_floor) rtt_floor = rtt;
      if (delay_cnt < HIST) begin
         delay_hist[delay_cnt] = rtt - rtt_floor;
         delay_cnt++;
      end else begin
         for (int i = 0; i < HIST - 1; i++) delay_hist[i] = delay_hist[i + 1];
         delay_hist[HIST - 1] = rtt - rtt_floor;
      end
      for (int i = 0; i < delay_cnt; i++) delay_sum += 64'(delay_hist[i]);
      if (echoed == cwnd && streak_cnt != STREAK_MAX) streak_cnt++;
      if (64'(streak_cnt) >= 64'(cwnd) * 64'(hold_cfg)) begin
         // mean compared against thresholds without a divide
         if (delay_sum < 64'(alpha_cfg) * 64'(delay_cnt)) begin
            if (cwnd != WIN_MAX) begin
               cwnd++;
               d.act = ACT_INC;
            end
            streak_cnt = '0;
         end else if (delay_sum > 64'(beta_cfg) * 64'(delay_cnt)) begin
            if (cwnd > WIN_MIN) begin
               cwnd--;
               d.act = ACT_DEC;
            end
            streak_cnt = '0;
         end
      end
      d.window = cwnd;
      queued_decisions.push_back(d);
   endtask

   // check responses, predict accepted transactions, mirror register writes
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (queued_decisions.size() == 0) begin
               $display("%0t: unexpected response window %0d action %0d", $time,
                        rsp_cwnd, rsp_action);
               fail_count++;
            end else begin
               seen = queued_decisions.pop_front();
               if (rsp_cwnd !== seen.window) begin
                  $display("%0t: cwnd expected %0d actual %0d", $time,
                           seen.window, rsp_cwnd);
                  fail_count++;
               end
               if (rsp_action !== seen.act) begin
                  $display("%0t: action expected %0d actual %0d", $time,
                           seen.act, rsp_action);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) decide_window(req_rtt_us, req_echoed_window);
         if (csr_we) begin
            case (csr_index)
               CSR_ALPHA: alpha_cfg = csr_wdata;
               CSR_BETA:  beta_cfg = csr_wdata;
               CSR_HOLD:  hold_cfg = csr_wdata[HOLD_W-1:0];
               default: ;
            endcase
         end
         req_taken <= req_valid && req_ready;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // acknowledgement driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && !req_taken) begin
         // hold the transaction until it is taken
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (ack_backlog.size() > 0) begin
         next_ack = ack_backlog.pop_front();
         req_valid <= 1'b1;
         req_rtt_us <= next_ack.rtt;
         req_echoed_window <= next_ack.track ? cwnd : next_ack.echoed;
         req_gap <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         int g;
         g = pick_gap();
         rsp_ready <= (g == 0);
         rsp_stall <= (g > 0) ? g - 1 : 0;
      end
   end

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_ack(input logic [RTT_W-1:0] rtt, input logic [WIN_W-1:0] echoed,
                            input bit track);
      ack_type a;
      a.rtt = rtt;
      a.echoed = echoed;
      a.track = track;
      ack_backlog.push_back(a);
   endtask

   task automatic queue_random(input int count, input int base, input int spread,
                               input int match_pct);
      ack_type a;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 19) == 0) a.rtt = RTT_W'($urandom());
         else a.rtt = RTT_W'(base + $urandom_range(0, spread));
         a.echoed = WIN_W'($urandom());
         a.track = ($urandom_range(0, 99) < match_pct);
         ack_backlog.push_back(a);
      end
   endtask

   // sender stays quiet until every decision has come back
   task automatic wait_idle();
      while (ack_backlog.size() != 0 || req_valid || queued_decisions.size() != 0)
         @(posedge clock);
      repeat (HIST + 8) @(negedge clock);
   endtask

   initial begin : stimulus
      int alpha_v, beta_v, hold_v, base_v, spread_v, match_v, count_v;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // history filling under reset registers, falling minimum rtt
      queue_ack(24'hFFFFFF, 16'hFFFF, 1'b0);
      queue_ack(24'd5000000, 16'h0000, 1'b0);
      queue_ack(24'd100, 16'd0, 1'b1);
      queue_ack(24'd0, 16'd0, 1'b1);
      queue_ack(24'hFFFFFF, 16'd0, 1'b1);
      wait_idle();

      // zero hold factor and zero thresholds: shrink every time, then stick at one
      write_csr(CSR_HOLD, '0);
      write_csr(CSR_ALPHA, '0);
      write_csr(CSR_BETA, '0);
      for (int k = 0; k < 12; k++) queue_ack(RTT_W'($urandom_range(1000, 24'hFFFFFF)), '0, 1'b1);
      wait_idle();

      // thresholds at maximum: grow every time
      write_csr(CSR_ALPHA, 24'hFFFFFF);
      write_csr(CSR_BETA, 24'hFFFFFF);
      for (int k = 0; k < 6; k++) queue_ack(RTT_W'($urandom_range(0, 50)), '0, 1'b1);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         calm <= (p == 3);
         case (p)
            0: begin alpha_v = 1500; beta_v = 2500; hold_v = 1; base_v = 0;
                     spread_v = 4000; match_v = 90; count_v = 60; end
            1: begin alpha_v = 2000; beta_v = 2000; hold_v = 2; base_v = 1000;
                     spread_v = 2000; match_v = 90; count_v = 60; end
            2: begin alpha_v = 0; beta_v = 0; hold_v = 0; base_v = 0;
                     spread_v = 24'hFFFFFF; match_v = 70; count_v = 40; end
            3: begin alpha_v = 3000; beta_v = 3000; hold_v = 1; base_v = 0;
                     spread_v = 6000; match_v = 90; count_v = 60; end
            4: begin alpha_v = $urandom_range(0, 24'hFFFFFF);
                     beta_v = $urandom_range(0, 24'hFFFFFF);
                     hold_v = $urandom_range(0, 3); base_v = 0;
                     spread_v = 24'hFFFFFF; match_v = 80; count_v = 50; end
            5: begin alpha_v = 1000000; beta_v = 3000000; hold_v = 1; base_v = 0;
                     spread_v = 4000000; match_v = 90; count_v = 50; end
            6: begin alpha_v = 5000; beta_v = 6000; hold_v = 1023; base_v = 0;
                     spread_v = 10000; match_v = 95; count_v = 20; end
            default: begin alpha_v = 24'hFFFFFF; beta_v = 24'hFFFFFF; hold_v = 0;
                     base_v = 0; spread_v = 5000; match_v = 60; count_v = 40; end
         endcase
         write_csr(CSR_ALPHA, CSR_DATA_W'(alpha_v));
         write_csr(CSR_BETA, CSR_DATA_W'(beta_v));
         write_csr(CSR_HOLD, CSR_DATA_W'(hold_v));
         queue_random(count_v, base_v, spread_v, match_v);
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
